### hw/rtl/ring_scratch_allocator_defines.svh
// ----------------------------------------------------------------------------
// Ring scratch allocator assertion macros
// Shared property templates for the allocator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef RING_SCRATCH_ALLOCATOR_DEFINES_SVH
`define RING_SCRATCH_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RSA_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RSA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ring scratch allocator package
// Status codes, header word constants and the result type.
// ----------------------------------------------------------------------------
package rsa_pkg;

    localparam logic [1:0] ST_SERVED      = 2'd0;
    localparam logic [1:0] ST_FORWARD     = 2'd1;
    localparam logic [1:0] ST_DOUBLE_FREE = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [31:0] FREE_BIT  = 32'h8000_0000;
    localparam logic [31:0] SIZE_MASK = 32'h7fff_ffff;
    localparam logic [31:0] PAD_WORD  = 32'hffff_ffff;

    localparam logic [16:0] ROUND_M1  = 17'd3;
    localparam logic [3:0]  ALIGN_MIN = 4'd2;
    localparam logic [3:0]  ALIGN_MAX = 4'd8;

    typedef struct packed {
        logic [11:0] data_offset;
        logic [1:0]  status;
    } result_t;

endpackage
`default_nettype wire

### hw/rtl/rsa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### hw/rtl/rsa_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ring scratch allocator sequencer
// Runs allocate and free items against the header memory and the ring pointers.
// ----------------------------------------------------------------------------
module rsa_seq #(
    parameter int BUFFER_BYTES = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                mode,
    input  wire logic [15:0]                         request_bytes,
    input  wire logic [3:0]                          align_log2,
    input  wire logic [15:0]                         free_offset,
    output logic                                     mem_we,
    output logic      [$clog2(BUFFER_BYTES/4)-1:0]   mem_waddr,
    output logic      [31:0]                         mem_wdata,
    output logic      [$clog2(BUFFER_BYTES/4)-1:0]   mem_raddr,
    input  wire logic [31:0]                         mem_rdata,
    output logic                                     res_valid,
    output rsa_pkg::result_t                         res,
    input  wire logic                                res_take
);

    localparam int WORDS = BUFFER_BYTES / 4;
    localparam int AW    = $clog2(BUFFER_BYTES + 1);
    localparam int CW    = AW + 3;
    localparam int IW    = $clog2(WORDS);
    localparam int NW    = $clog2(WORDS + 1);

    localparam logic [AW-1:0] BUF_END    = AW'(BUFFER_BYTES);
    localparam logic [CW-1:0] BUF_END_C  = CW'(BUFFER_BYTES);
    localparam logic [16:0]   BUF_END_17 = 17'(BUFFER_BYTES);
    localparam logic [NW-1:0] WALK_MAX   = NW'(WORDS);
    localparam logic [CW-1:0] HDR_BYTES  = CW'(4);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_A_PREP  = 4'd1;
    localparam logic [3:0] S_A_FIT   = 4'd2;
    localparam logic [3:0] S_A_PAD   = 4'd3;
    localparam logic [3:0] S_F_START = 4'd4;
    localparam logic [3:0] S_F_READ  = 4'd5;
    localparam logic [3:0] S_F_CHECK = 4'd6;
    localparam logic [3:0] S_W_READ  = 4'd7;
    localparam logic [3:0] S_W_CHECK = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [AW-1:0]    alloc_ptr_reg, alloc_ptr_next;
    logic [AW-1:0]    release_ptr_reg, release_ptr_next;
    logic             wrapped_reg, wrapped_next;
    logic [NW-1:0]    walk_cnt_reg, walk_cnt_next;

    logic [15:0]      req_reg, req_next;
    logic [3:0]       lg_reg, lg_next;
    logic [15:0]      off_reg, off_next;
    logic [CW-1:0]    size_reg, size_next;
    logic             too_big_reg, too_big_next;
    logic [AW-1:0]    h_reg, h_next;
    logic [CW-1:0]    data_reg, data_next;
    logic [CW-1:0]    p_reg, p_next;
    logic [CW-1:0]    w_reg, w_next;
    logic [IW-1:0]    idx_reg, idx_next;
    rsa_pkg::result_t res_reg, res_next;

    logic [3:0]       lg_clamp;
    logic [8:0]       align_m1;
    logic [16:0]      size_round;
    logic [AW-1:0]    h_start;
    logic [CW-1:0]    data_first;
    logic [CW-1:0]    p_sum;
    logic             occupied;
    logic [AW-1:0]    walk_step;
    logic             walk_step_ok;
    logic [AW-1:0]    release_sum;

    assign lg_clamp = (lg_reg < rsa_pkg::ALIGN_MIN) ? rsa_pkg::ALIGN_MIN :
                      (lg_reg > rsa_pkg::ALIGN_MAX) ? rsa_pkg::ALIGN_MAX : lg_reg;
    assign align_m1   = (9'd1 << lg_clamp) - 9'd1;
    assign size_round = ({1'b0, req_reg} + rsa_pkg::ROUND_M1) & ~rsa_pkg::ROUND_M1;
    assign h_start    = (alloc_ptr_reg >= BUF_END) ? '0 : alloc_ptr_reg;
    assign data_first = (CW'(h_start) + HDR_BYTES + CW'(align_m1)) & ~CW'(align_m1);
    assign p_sum      = data_reg + size_reg;

    assign occupied = (release_ptr_reg != alloc_ptr_reg) &&
        ((alloc_ptr_reg > release_ptr_reg) ?
            ((p_sum >= CW'(release_ptr_reg)) && (p_sum < CW'(alloc_ptr_reg))) :
            ((p_sum >= CW'(release_ptr_reg)) || (p_sum < CW'(alloc_ptr_reg))));

    assign walk_step    = mem_rdata[AW-1:0] & rsa_pkg::SIZE_MASK[AW-1:0];
    assign walk_step_ok = (mem_rdata[30:AW] == '0) && (walk_step != '0) &&
                          (walk_step <= (BUF_END - release_ptr_reg));
    assign release_sum  = release_ptr_reg + walk_step;

    assign in_stall  = (state_reg != S_IDLE);
    assign res       = res_reg;

    always_comb
    begin
        state_next       = state_reg;
        alloc_ptr_next   = alloc_ptr_reg;
        release_ptr_next = release_ptr_reg;
        wrapped_next     = wrapped_reg;
        walk_cnt_next    = walk_cnt_reg;
        req_next         = req_reg;
        lg_next          = lg_reg;
        off_next         = off_reg;
        size_next        = size_reg;
        too_big_next     = too_big_reg;
        h_next           = h_reg;
        data_next        = data_reg;
        p_next           = p_reg;
        w_next           = w_reg;
        idx_next         = idx_reg;
        res_next         = res_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_raddr        = '0;
        res_valid        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next     = request_bytes;
                    lg_next      = align_log2;
                    off_next     = free_offset;
                    wrapped_next = 1'b0;
                    state_next   = (mode == rsa_pkg::MODE_FREE) ? S_F_START : S_A_PREP;
                end
            end
            S_A_PREP:
            begin
                size_next    = CW'(size_round);
                too_big_next = (size_round > BUF_END_17);
                h_next       = h_start;
                data_next    = data_first;
                state_next   = S_A_FIT;
            end
            S_A_FIT:
            begin
                res_next.data_offset = '0;
                res_next.status      = rsa_pkg::ST_FORWARD;
                if (too_big_reg)
                begin
                    state_next = S_DONE;
                end
                else if (p_sum > BUF_END_C)
                begin
                    if (!wrapped_reg)
                    begin
                        mem_we       = 1'b1;
                        mem_waddr    = h_reg[IW+1:2];
                        mem_wdata    = rsa_pkg::FREE_BIT | 32'(BUF_END - h_reg);
                        h_next       = '0;
                        data_next    = CW'(align_m1) + CW'(1);
                        wrapped_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (occupied)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = h_reg[IW+1:2];
                    mem_wdata  = 32'(p_sum - CW'(h_reg));
                    p_next     = p_sum;
                    w_next     = CW'(h_reg) + HDR_BYTES;
                    state_next = S_A_PAD;
                end
            end
            S_A_PAD:
            begin
                if (w_reg < data_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = w_reg[IW+1:2];
                    mem_wdata = rsa_pkg::PAD_WORD;
                    w_next    = w_reg + HDR_BYTES;
                end
                else
                begin
                    alloc_ptr_next       = AW'(p_reg);
                    res_next.data_offset = 12'(data_reg);
                    res_next.status      = rsa_pkg::ST_SERVED;
                    state_next           = S_DONE;
                end
            end
            S_F_START:
            begin
                res_next.data_offset = '0;
                if ({1'b0, off_reg} >= BUF_END_17)
                begin
                    res_next.status = rsa_pkg::ST_FORWARD;
                    state_next      = S_DONE;
                end
                else if (off_reg < 16'd4)
                begin
                    res_next.status = rsa_pkg::ST_SERVED;
                    state_next      = S_DONE;
                end
                else
                begin
                    res_next.status = rsa_pkg::ST_SERVED;
                    idx_next        = IW'(off_reg[15:2] - 14'd1);
                    state_next      = S_F_READ;
                end
            end
            S_F_READ:
            begin
                mem_raddr  = idx_reg;
                state_next = S_F_CHECK;
            end
            S_F_CHECK:
            begin
                if ((idx_reg != '0) && (mem_rdata == rsa_pkg::PAD_WORD))
                begin
                    idx_next   = idx_reg - IW'(1);
                    state_next = S_F_READ;
                end
                else if ((mem_rdata & rsa_pkg::FREE_BIT) != '0)
                begin
                    res_next.status = rsa_pkg::ST_DOUBLE_FREE;
                    state_next      = S_DONE;
                end
                else
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = idx_reg;
                    mem_wdata     = mem_rdata | rsa_pkg::FREE_BIT;
                    walk_cnt_next = '0;
                    state_next    = S_W_READ;
                end
            end
            S_W_READ:
            begin
                if ((release_ptr_reg == alloc_ptr_reg) || (walk_cnt_reg == WALK_MAX))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr  = release_ptr_reg[IW+1:2];
                    state_next = S_W_CHECK;
                end
            end
            S_W_CHECK:
            begin
                if (((mem_rdata & rsa_pkg::FREE_BIT) == '0) || !walk_step_ok)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    walk_cnt_next = walk_cnt_reg + NW'(1);
                    if (release_sum == BUF_END)
                    begin
                        release_ptr_next = '0;
                        if (alloc_ptr_reg == BUF_END)
                        begin
                            alloc_ptr_next = '0;
                        end
                    end
                    else
                    begin
                        release_ptr_next = release_sum;
                    end
                    state_next = S_W_READ;
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            alloc_ptr_reg   <= '0;
            release_ptr_reg <= '0;
            wrapped_reg     <= 1'b0;
            walk_cnt_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            alloc_ptr_reg   <= alloc_ptr_next;
            release_ptr_reg <= release_ptr_next;
            wrapped_reg     <= wrapped_next;
            walk_cnt_reg    <= walk_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        lg_reg      <= lg_next;
        off_reg     <= off_next;
        size_reg    <= size_next;
        too_big_reg <= too_big_next;
        h_reg       <= h_next;
        data_reg    <= data_next;
        p_reg       <= p_next;
        w_reg       <= w_next;
        idx_reg     <= idx_next;
        res_reg     <= res_next;
    end

endmodule
`default_nettype wire

### hw/rtl/ring_scratch_allocator.sv
// Allocate: prepare size and alignment, fit the slot (writing a wrap header once if needed),
// write padding words, then offer the result. Free: search back over padding to the header,
// mark it free and walk freed slots; a double free ends at the check and forwards end early.
// One item at a time; the next is accepted while the previous result waits in the output.
// Reset clears the pointers and control; the header memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "ring_scratch_allocator_defines.svh"
// ----------------------------------------------------------------------------
// Ring scratch allocator
// Ring allocation of slots with headers in a word memory, and release walking.
// ----------------------------------------------------------------------------
module ring_scratch_allocator #(
    parameter int BUFFER_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [15:0] request_bytes,
    input  wire logic [3:0]  align_log2,
    input  wire logic [15:0] free_offset,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [11:0] data_offset,
    output logic      [1:0]  status
);

    localparam int WORDS = BUFFER_BYTES / 4;
    localparam int IW    = $clog2(WORDS);

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    logic [31:0]      mem_wdata;
    logic [IW-1:0]    mem_raddr;
    logic [31:0]      mem_rdata;
    logic             res_valid;
    rsa_pkg::result_t res;
    logic             res_take;

    logic             out_valid_reg, out_valid_next;
    logic [11:0]      data_offset_reg, data_offset_next;
    logic [1:0]       status_reg, status_next;

    rsa_ram #(
        .WIDTH (32),
        .DEPTH (WORDS)
    ) u_header_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rsa_seq #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .request_bytes (request_bytes),
        .align_log2    (align_log2),
        .free_offset   (free_offset),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata),
        .res_valid     (res_valid),
        .res           (res),
        .res_take      (res_take)
    );

    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next   = (res_valid && res_take) || (out_valid_reg && out_stall);
        data_offset_next = data_offset_reg;
        status_next      = status_reg;
        if (res_valid && res_take)
        begin
            data_offset_next = res.data_offset;
            status_next      = res.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_offset_reg <= data_offset_next;
        status_reg      <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign data_offset = data_offset_reg;
    assign status      = status_reg;

    `RSA_ASSERT_IMPL(a_result_while_busy, res_valid, in_stall, "result offered while idle")
    `RSA_ASSERT_IMPL(a_write_while_busy, mem_we, in_stall, "header write while idle")
    `RSA_ASSERT_NEXT(a_accept_goes_busy, in_valid && !in_stall, in_stall, "no work after accept")
    `RSA_ASSERT_IMPL(a_offset_zero, out_valid_reg && (status_reg != rsa_pkg::ST_SERVED), data_offset_reg == 12'd0, "nonzero offset on unserved item")

endmodule
`default_nettype wire

### tb/ring_scratch_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring scratch allocator testbench
// Drives allocate and free items through the valid/stall handshake, with random
// gaps and stalls on both sides. A scoreboard keeps its own copy of the header
// words and ring pointers, predicts each result and checks it in order.
// ----------------------------------------------------------------------------
module ring_scratch_allocator_test;
    import rsa_pkg::*;

    localparam int BUFFER_BYTES = 4096;
    localparam int STORE_WORDS  = BUFFER_BYTES / 4;
    localparam int RANDOM_ITEMS = 1450;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 50;

    typedef struct {
        logic        mode;
        logic [15:0] request_bytes;
        logic [3:0]  align_log2;
        logic [15:0] free_offset;
    } alloc_request_t;

    class slot_ring_scoreboard;
        bit [31:0]   header_words[STORE_WORDS];
        bit          word_written[STORE_WORDS];
        int unsigned alloc_ptr;
        int unsigned release_ptr;
        result_t     pending_results[$];
        int          errors;

        function new();
            alloc_ptr = 0;
            release_ptr = 0;
            errors = 0;
            foreach (header_words[i])
            begin
                header_words[i] = '0;
                word_written[i] = 1'b0;
            end
        endfunction

        function void put_word(int unsigned byte_off, bit [31:0] value);
            if ((byte_off >> 2) < STORE_WORDS)
            begin
                header_words[byte_off >> 2] = value;
                word_written[byte_off >> 2] = 1'b1;
            end
        endfunction

        function bit [31:0] peek_word(int unsigned byte_off);
            return ((byte_off >> 2) < STORE_WORDS) ? header_words[byte_off >> 2] : '0;
        endfunction

        function bit in_live_span(int unsigned p);
            if (release_ptr == alloc_ptr)
                return 1'b0;
            if (alloc_ptr > release_ptr)
                return p >= release_ptr && p < alloc_ptr;
            return p >= release_ptr || p < alloc_ptr;
        endfunction

        function result_t place_slot(logic [15:0] req, logic [3:0] lg);
            int unsigned size, shift, align, h, data_at, p, w;
            result_t r;
            r.data_offset = '0;
            r.status = ST_FORWARD;
            size = (32'(req) + 3) & ~32'd3;
            shift = 32'(lg);
            if (shift < ALIGN_MIN)
                shift = ALIGN_MIN;
            if (shift > ALIGN_MAX)
                shift = ALIGN_MAX;
            align = 1 << shift;
            if (size > BUFFER_BYTES)
                return r;
            h = alloc_ptr;
            if (h >= BUFFER_BYTES)
                h = 0;
            data_at = (h + 4 + align - 1) & ~(align - 1);
            p = data_at + size;
            if (p > BUFFER_BYTES)
            begin
                if (h < BUFFER_BYTES)
                    put_word(h, (BUFFER_BYTES - h) | FREE_BIT);
                h = 0;
                data_at = (4 + align - 1) & ~(align - 1);
                p = data_at + size;
                if (p > BUFFER_BYTES)
                    return r;
            end
            if (in_live_span(p))
                return r;
            put_word(h, p - h);
            for (w = h + 4; w < data_at; w += 4)
                put_word(w, PAD_WORD);
            alloc_ptr = p;
            r.data_offset = 12'(data_at);
            r.status = ST_SERVED;
            return r;
        endfunction

        function result_t release_slot(logic [15:0] off);
            int unsigned idx, n, step;
            bit [31:0] word, hw;
            result_t r;
            r.data_offset = '0;
            r.status = ST_FORWARD;
            if (off >= BUFFER_BYTES)
                return r;
            r.status = ST_SERVED;
            if (off < 4)
                return r;
            idx = 32'(off >> 2) - 1;
            while (idx > 0 && header_words[idx] == PAD_WORD)
                idx--;
            word = header_words[idx];
            if ((word & FREE_BIT) != 0)
            begin
                r.status = ST_DOUBLE_FREE;
                return r;
            end
            header_words[idx] = word | FREE_BIT;
            for (n = 0; n < STORE_WORDS && release_ptr != alloc_ptr; n++)
            begin
                hw = peek_word(release_ptr);
                step = hw & SIZE_MASK;
                if ((hw & FREE_BIT) == 0)
                    break;
                if (step == 0 || step > BUFFER_BYTES - release_ptr)
                    break;
                release_ptr += step;
                if (release_ptr == BUFFER_BYTES)
                begin
                    if (alloc_ptr == BUFFER_BYTES)
                        alloc_ptr = 0;
                    release_ptr = 0;
                end
            end
            return r;
        endfunction

        // A free is only issued when its backward header search reads written words.
        function bit search_known(logic [15:0] off);
            int unsigned idx;
            if (off >= BUFFER_BYTES || off < 4)
                return 1'b1;
            idx = 32'(off >> 2) - 1;
            while (word_written[idx] && idx > 0 && header_words[idx] == PAD_WORD)
                idx--;
            return word_written[idx];
        endfunction

        function result_t note_request(alloc_request_t q);
            result_t r;
            if (q.mode == MODE_ALLOC)
                r = place_slot(q.request_bytes, q.align_log2);
            else
                r = release_slot(q.free_offset);
            pending_results.push_back(r);
            return r;
        endfunction

        function void check_result(logic [11:0] got_offset, logic [1:0] got_status);
            result_t e;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result data_offset=%0d status=%0d",
                         $time, got_offset, got_status);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (got_offset !== e.data_offset)
            begin
                $display("%0t: data_offset mismatch, expected %0d, actual %0d",
                         $time, e.data_offset, got_offset);
                errors++;
            end
            if (got_status !== e.status)
            begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, e.status, got_status);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [15:0] request_bytes;
    logic [3:0]  align_log2;
    logic [15:0] free_offset;
    logic        out_valid;
    logic        out_stall;
    logic [11:0] data_offset;
    logic [1:0]  status;

    slot_ring_scoreboard sb;
    logic [11:0]         live_offsets[$];
    logic [11:0]         freed_offsets[$];
    bit                  calm_phase;

    ring_scratch_allocator #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .request_bytes(request_bytes),
        .align_log2(align_log2),
        .free_offset(free_offset),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .data_offset(data_offset),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (calm_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input alloc_request_t q);
        int gap;
        result_t e;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= q.mode;
        request_bytes <= q.request_bytes;
        align_log2 <= q.align_log2;
        free_offset <= q.free_offset;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        e = sb.note_request(q);
        if (q.mode == MODE_ALLOC && e.status == ST_SERVED)
            live_offsets.push_back(e.data_offset);
    endtask

    task automatic alloc_item(input logic [15:0] req, input logic [3:0] lg);
        alloc_request_t q;
        q.mode = MODE_ALLOC;
        q.request_bytes = req;
        q.align_log2 = lg;
        q.free_offset = 16'($urandom_range(0, 65535));
        send_request(q);
    endtask

    task automatic free_item(input logic [15:0] off);
        alloc_request_t q;
        q.mode = MODE_FREE;
        q.request_bytes = 16'($urandom_range(0, 65535));
        q.align_log2 = 4'($urandom_range(0, 15));
        q.free_offset = off;
        send_request(q);
    endtask

    task automatic release_live(input int idx, input int skew);
        logic [11:0] off;
        logic [15:0] target;
        off = live_offsets[idx];
        live_offsets.delete(idx);
        freed_offsets.push_back(off);
        if (freed_offsets.size() > 16)
            void'(freed_offsets.pop_front());
        target = 16'(off) + 16'(skew);
        free_item(sb.search_known(target) ? target : 16'(BUFFER_BYTES));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_item();
        int r;
        int k;
        logic [15:0] off;
        r = $urandom_range(0, 99);
        if (live_offsets.size() > 0 && (r < 40 || live_offsets.size() > 14))
        begin
            if ($urandom_range(0, 9) < 7)
                release_live(0, $urandom_range(0, 3));
            else
                release_live($urandom_range(0, live_offsets.size() - 1), 0);
        end
        else if (r < 48)
        begin
            k = $urandom_range(0, 4);
            case (k)
                0: free_item(16'($urandom_range(BUFFER_BYTES, 65535)));
                1: free_item(16'($urandom_range(0, 3)));
                2:
                begin
                    off = 16'($urandom_range(4, BUFFER_BYTES - 1));
                    if (freed_offsets.size() > 0)
                        off = 16'(freed_offsets[$urandom_range(0, freed_offsets.size() - 1)]);
                    free_item(sb.search_known(off) ? off : 16'(BUFFER_BYTES));
                end
                3:
                begin
                    off = 16'($urandom_range(4, BUFFER_BYTES - 1));
                    free_item(sb.search_known(off) ? off : 16'hffff);
                end
                default:
                    alloc_item(16'($urandom_range(BUFFER_BYTES - 2, 65535)),
                               4'($urandom_range(0, 15)));
            endcase
        end
        else
        begin
            k = $urandom_range(0, 99);
            if (k < 70)
                off = 16'($urandom_range(0, 64));
            else if (k < 92)
                off = 16'($urandom_range(65, 600));
            else if (k < 99)
                off = 16'($urandom_range(601, 2500));
            else
                off = 16'($urandom_range(2501, BUFFER_BYTES));
            alloc_item(off, ($urandom_range(0, 99) < 85) ? 4'($urandom_range(2, 8))
                                                          : 4'($urandom_range(0, 15)));
        end
    endtask

    initial
    begin : result_sink
        int  run;
        bit  hold;
        run = 0;
        hold = 1'b0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_result(data_offset, status);
            if (run == 0)
            begin
                if (hold)
                begin
                    hold = 1'b0;
                    run = $urandom_range(1, 8);
                end
                else
                begin
                    run = pick_gap();
                    hold = run > 0;
                    if (!hold)
                        run = $urandom_range(1, 8);
                end
            end
            out_stall <= hold;
            run--;
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        sb = new();
        calm_phase = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        mode <= MODE_ALLOC;
        request_bytes <= '0;
        align_log2 <= '0;
        free_offset <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        free_item(16'd0);
        free_item(16'd3);
        free_item(16'(BUFFER_BYTES));
        free_item(16'hffff);
        alloc_item(16'd0, 4'd0);
        alloc_item(16'hffff, 4'hf);
        alloc_item(16'(BUFFER_BYTES - 3), 4'd2);
        alloc_item(16'd100, 4'hf);
        alloc_item(16'd1, 4'd3);
        alloc_item(16'd2, 4'd4);
        alloc_item(16'd3, 4'd5);
        alloc_item(16'd9, 4'd8);
        release_live(1, 2);
        release_live(0, 0);
        free_item(16'(freed_offsets[freed_offsets.size() - 1]));
        while (live_offsets.size() > 0)
            release_live(live_offsets.size() - 1, 0);
        wait_for_results();
        alloc_item(16'(BUFFER_BYTES - sb.alloc_ptr - 4), 4'd2);
        alloc_item(16'd8, 4'd2);
        alloc_item(16'd4000, 4'd2);
        release_live(0, 1);
        release_live(0, 3);
        wait_for_results();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm_phase = (n % 250) >= 200;
            if (n == RANDOM_ITEMS / 2)
                wait_for_results();
            random_item();
        end
        calm_phase = 1'b0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
